// File: rtl/tbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants of the tagged branch predictor table.
// ----------------------------------------------------------------------------
package tbp_pkg;

	localparam logic [31:0] HIST_HIGH_MASK = 32'hFFFF_FF00;
	localparam logic [5:0]  LIMIT_RESET    = 6'd31;
	localparam logic [1:0]  CTR_INIT       = 2'b01;
	localparam logic [1:0]  CTR_MAX        = 2'b11;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic clr_en;
		logic rd_en;
		logic scan_init;
		logic scan_en;
		logic wr_en;
		logic out_load;
	} tbp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic accepted;
		logic clr_last;
		logic div_done;
		logic scan_last;
		logic out_free;
	} tbp_sts_t;

endpackage

// File: rtl/tbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_if
// Valid/ready channels for predictor requests and results.
// ----------------------------------------------------------------------------
interface tbp_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] branch_pc;
	logic [31:0] global_history;
	logic [31:0] tag_extra;
	logic        actual_taken;
	logic        base_prediction;
	logic        table_prediction;

	modport source (output valid, kind, branch_pc, global_history, tag_extra,
		actual_taken, base_prediction, table_prediction, input ready);
	modport sink (input valid, kind, branch_pc, global_history, tag_extra,
		actual_taken, base_prediction, table_prediction, output ready);
endinterface

interface tbp_out_if;
	logic valid;
	logic ready;
	logic hit;
	logic predict_taken;

	modport source (output valid, hit, predict_taken, input ready);
	modport sink (input valid, hit, predict_taken, output ready);
endinterface

// File: rtl/tbp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_div
// Quotient and remainder by a power-of-two constant, registered on start.
// ----------------------------------------------------------------------------
module tbp_div #(
	parameter int DIVISOR = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [31:0]                 dividend,
	output logic [31:0]                 quot,
	output logic [$clog2(DIVISOR):0]    rem,
	output logic                        done
);
	// DIVISOR must be a power of two: the split is a shift and a mask
	localparam int SH = $clog2(DIVISOR);
	localparam int RW = SH + 1;

	logic          done_q;
	logic [31:0]   quot_q;
	logic [RW-1:0] rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend >> SH;
			rem_q  <= {1'b0, dividend[SH-1:0]};
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule

// File: rtl/tbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_ctrl
// Sequencer: clear pass, divide, row read, way scan, row write, result.
// ----------------------------------------------------------------------------
module tbp_ctrl
	import tbp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  tbp_sts_t sts,
	output tbp_cmd_t cmd
);
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_WRITE = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.accepted) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd_en     = 1'b1;
				cmd.scan_init = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_last) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				// hold until the result slot drains
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: rtl/tbp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_datapath
// Index and tag math, set-row memories, way scan and row update.
// ----------------------------------------------------------------------------
module tbp_datapath
	import tbp_pkg::*;
#(
	parameter int SET_COUNT        = 256,
	parameter int WAY_COUNT        = 4,
	parameter int COUNTERS_PER_WAY = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [5:0]      cfg_wdata,
	tbp_in_if.sink          req,
	tbp_out_if.source       rsp,
	input  tbp_cmd_t        cmd,
	output tbp_sts_t        sts
);
	localparam int SET_W = $clog2(SET_COUNT);
	localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	localparam int SEL_W = (COUNTERS_PER_WAY > 1) ? $clog2(COUNTERS_PER_WAY) : 1;

	typedef logic [WAY_COUNT-1:0]                         vrow_t;
	typedef logic [WAY_COUNT-1:0][31:0]                   trow_t;
	typedef logic [WAY_COUNT-1:0][5:0]                    urow_t;
	typedef logic [WAY_COUNT-1:0][COUNTERS_PER_WAY-1:0][1:0] crow_t;

	vrow_t valid_mem [SET_COUNT];
	trow_t tag_mem   [SET_COUNT];
	urow_t use_mem   [SET_COUNT];
	crow_t ctr_mem   [SET_COUNT];

	logic [5:0]  lim_q;
	logic        accept;
	logic        kind_q, actual_q, basep_q, tablep_q;
	logic [31:0] hist_q, extra_q;
	logic [31:0] set_quot, pc_quot;
	logic [SET_W:0] set_rem, pc_rem;
	logic        set_done, pc_done;
	logic [SET_W-1:0] set_idx, clr_cnt_q, wr_addr;
	logic [SEL_W-1:0] sel;
	logic [31:0] tag;

	vrow_t v_row_q, v_new, v_clr;
	trow_t t_row_q, t_new;
	urow_t u_row_q, u_new;
	crow_t c_row_q, c_new, c_clr;

	logic [WAY_W-1:0] scan_cnt_q, hit_way_q, free_way_q, min_way_q, victim;
	logic             hit_q, free_q;
	logic [5:0]       min_q;
	logic             out_valid_q, out_hit_q, out_pred_q;
	logic             mem_wr;

	assign accept = req.valid && cmd.in_ready;
	assign req.ready = cmd.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			lim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= req.kind;
			hist_q   <= req.global_history;
			extra_q  <= req.tag_extra;
			actual_q <= req.actual_taken;
			basep_q  <= req.base_prediction;
			tablep_q <= req.table_prediction;
		end
	end

	tbp_div #(.DIVISOR(SET_COUNT)) u_set_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend ({2'b00, req.branch_pc[31:2] ^ req.global_history[31:2]}),
		.quot     (set_quot),
		.rem      (set_rem),
		.done     (set_done)
	);

	tbp_div #(.DIVISOR(SET_COUNT)) u_pc_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (req.branch_pc),
		.quot     (pc_quot),
		.rem      (pc_rem),
		.done     (pc_done)
	);

	assign set_idx = set_rem[SET_W-1:0];
	assign tag     = pc_quot ^ (hist_q & HIST_HIGH_MASK) ^ extra_q;
	assign sel     = SEL_W'(hist_q & 32'(COUNTERS_PER_WAY - 1));

	// clear pass after reset: one set row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + SET_W'(1);
		end
	end

	always_comb begin
		v_clr = '0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			for (int c = 0; c < COUNTERS_PER_WAY; c++) begin
				c_clr[w][c] = CTR_INIT;
			end
		end
	end

	assign mem_wr  = cmd.wr_en && kind_q;
	assign wr_addr = cmd.clr_en ? clr_cnt_q : set_idx;

	always_ff @(posedge clk) begin
		if (cmd.clr_en || mem_wr) begin
			valid_mem[wr_addr] <= cmd.clr_en ? v_clr : v_new;
			ctr_mem[wr_addr]   <= cmd.clr_en ? c_clr : c_new;
		end
		if (cmd.rd_en) begin
			v_row_q <= valid_mem[set_idx];
			c_row_q <= ctr_mem[set_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			tag_mem[set_idx] <= t_new;
			use_mem[set_idx] <= u_new;
		end
		if (cmd.rd_en) begin
			t_row_q <= tag_mem[set_idx];
			u_row_q <= use_mem[set_idx];
		end
	end

	// way scan: first match, first free way, first lowest count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
		end else if (cmd.scan_init) begin
			scan_cnt_q <= '0;
		end else if (cmd.scan_en) begin
			scan_cnt_q <= scan_cnt_q + WAY_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.scan_en) begin
			if (!hit_q && v_row_q[scan_cnt_q] && t_row_q[scan_cnt_q] == tag) begin
				hit_q     <= 1'b1;
				hit_way_q <= scan_cnt_q;
			end
			if (!free_q && !v_row_q[scan_cnt_q]) begin
				free_q     <= 1'b1;
				free_way_q <= scan_cnt_q;
			end
			if (scan_cnt_q == '0 || u_row_q[scan_cnt_q] < min_q) begin
				min_q     <= u_row_q[scan_cnt_q];
				min_way_q <= scan_cnt_q;
			end
		end
	end

	assign victim = free_q ? free_way_q : min_way_q;

	always_comb begin
		logic [5:0] cnt, c1, c2;
		logic [6:0] sum;
		logic       raise, sat;
		logic [1:0] cur;
		v_new = v_row_q;
		t_new = t_row_q;
		u_new = u_row_q;
		c_new = c_row_q;
		cnt   = u_row_q[hit_way_q];
		sum   = {1'b0, cnt} + 7'd2;
		raise = (actual_q == tablep_q) && (actual_q != basep_q) && (cnt < lim_q);
		sat   = raise && (sum >= {1'b0, lim_q});
		c1    = raise ? (sat ? lim_q : sum[5:0]) : cnt;
		c2    = c1;
		if (tablep_q == basep_q && c1 != 6'd0) begin
			c2 = (c1 <= 6'd2) ? 6'd0 : c1 - 6'd2;
		end
		cur = c_row_q[hit_way_q][sel];
		if (hit_q) begin
			for (int w = 0; w < WAY_COUNT; w++) begin
				if (sat && v_row_q[w] && WAY_W'(w) != hit_way_q) begin
					u_new[w] = u_row_q[w] >> 1;
				end
			end
			u_new[hit_way_q] = c2;
			if (actual_q) begin
				c_new[hit_way_q][sel] = (cur != CTR_MAX) ? cur + 2'd1 : cur;
			end else begin
				c_new[hit_way_q][sel] = (cur != 2'd0) ? cur - 2'd1 : cur;
			end
		end else begin
			v_new[victim]      = 1'b1;
			t_new[victim]      = tag;
			u_new[victim]      = 6'd0;
			c_new[victim][sel] = {1'b0, actual_q} + 2'd1;
		end
	end

	// result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_hit_q  <= hit_q;
			out_pred_q <= !kind_q && hit_q && c_row_q[hit_way_q][sel][1];
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.hit           = out_hit_q;
	assign rsp.predict_taken = out_pred_q;

	assign sts.accepted  = accept;
	assign sts.clr_last  = clr_cnt_q == SET_W'(SET_COUNT - 1);
	assign sts.div_done  = set_done && pc_done;
	assign sts.scan_last = scan_cnt_q == WAY_W'(WAY_COUNT - 1);
	assign sts.out_free  = !out_valid_q || rsp.ready;

	// quotient of the set divide and remainder of the pc divide go unused
	logic unused_bits;
	assign unused_bits = ^{set_quot, pc_rem};
endmodule

// File: rtl/tagged_branch_overriding_predictor_core.sv
`timescale 1ns / 1ps
// Steps from the accepting edge to result valid: the set and tag split, the row
// read, the one-way-per-cycle scan of all WAY_COUNT ways, the row write and the
// result load, which waits while the result slot is still full.
// Requests: one in flight; a new request is taken only after the result load.
// Reset: asynchronous; then a clearing pass over all SET_COUNT rows sets every
// way invalid and every counter to one before the first request is taken.
// ----------------------------------------------------------------------------
// tagged_branch_overriding_predictor_core
// Set-associative tagged predictor table with 2-bit direction counters.
// ----------------------------------------------------------------------------
module tagged_branch_overriding_predictor_core
	import tbp_pkg::*;
#(
	parameter int SET_COUNT        = 256,
	parameter int WAY_COUNT        = 4,
	parameter int COUNTERS_PER_WAY = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	tbp_in_if.sink     req,
	tbp_out_if.source  rsp
);
	tbp_cmd_t cmd;
	tbp_sts_t sts;

	tbp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	tbp_datapath #(
		.SET_COUNT        (SET_COUNT),
		.WAY_COUNT        (WAY_COUNT),
		.COUNTERS_PER_WAY (COUNTERS_PER_WAY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule

// File: rtl/tbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_checker
// Port-level checks of the predictor core, bound to the top level.
// ----------------------------------------------------------------------------
module tbp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_hit,
	input logic out_pred
);
	// one transaction in flight: ready drops right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted back to back");

	// a taken prediction comes only with a hit
	a_pred_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_pred || out_hit))
		else $error("prediction without hit");

	// a result never appears in the cycle after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_pred))
		else $error("stalled result changed");
endmodule

bind tagged_branch_overriding_predictor_core tbp_checker u_tbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_hit   (rsp.hit),
	.out_pred  (rsp.predict_taken)
);

// File: test/tagged_branch_overriding_predictor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_branch_overriding_predictor_core_tb
// Drives lookups and outcome feedback into the predictor table, keeps a
// shadow copy of the ways and counters, and checks each result in order
// under several idle and stall patterns and replacement limits.
// ----------------------------------------------------------------------------
module tagged_branch_overriding_predictor_core_tb;
	import tbp_pkg::*;

	localparam int SETS = 256;
	localparam int WAYS = 4;
	localparam int CTRS = 4;
	localparam int LINES = SETS * WAYS;
	localparam int LATENCY = 36 + WAYS;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef enum logic {KIND_LOOKUP = 1'b0, KIND_FEEDBACK = 1'b1} kind_e;

	typedef struct packed {
		logic hit;
		logic predict_taken;
	} prediction_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [5:0] cfg_wdata;

	tbp_in_if req ();
	tbp_out_if rsp ();

	tagged_branch_overriding_predictor_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req.sink), .rsp(rsp.source)
	);

	// shadow table
	logic [5:0]  limit_q;
	logic        line_valid [LINES];
	logic [31:0] line_tag [LINES];
	logic [5:0]  line_useful [LINES];
	logic [1:0]  dir_ctr [LINES*CTRS];

	prediction_t expected_q[$];
	int errors;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;

	// small pool of contexts so feedback trains and evicts the same sets
	logic [31:0] pool_pc [16];
	logic [31:0] pool_hist [16];
	logic [31:0] pool_extra [16];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic prediction_t predict_and_update(logic kind, logic [31:0] pc,
			logic [31:0] hist, logic [31:0] extra, logic actual, logic basep,
			logic tablep);
		prediction_t r;
		int base;
		int hw;
		int victim;
		int slot;
		int cnt;
		int best;
		logic [31:0] tag;
		logic found;
		base = int'(((pc ^ hist) >> 2) % SETS) * WAYS;
		tag = (pc / SETS) ^ (hist & HIST_HIGH_MASK) ^ extra;
		found = 1'b0;
		hw = 0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (line_valid[base+w] && line_tag[base+w] == tag) begin
				found = 1'b1;
				hw = w;
			end
		end
		r.hit = found;
		r.predict_taken = 1'b0;
		if (kind == KIND_LOOKUP) begin
			if (found)
				r.predict_taken = dir_ctr[(base+hw)*CTRS + int'(hist % CTRS)][1];
			return r;
		end
		if (found) begin
			slot = (base+hw)*CTRS + int'(hist % CTRS);
			cnt = int'(line_useful[base+hw]);
			if (actual == tablep && actual != basep && cnt < limit_q) begin
				cnt += 2;
				if (cnt >= limit_q) begin
					cnt = int'(limit_q);
					for (int w = 0; w < WAYS; w++)
						if (w != hw && line_valid[base+w])
							line_useful[base+w] = line_useful[base+w] >> 1;
				end
			end
			if (tablep == basep && cnt > 0)
				cnt = (cnt <= 2) ? 0 : cnt - 2;
			line_useful[base+hw] = cnt[5:0];
			if (actual && dir_ctr[slot] != CTR_MAX)
				dir_ctr[slot] = dir_ctr[slot] + 2'd1;
			else if (!actual && dir_ctr[slot] != 2'd0)
				dir_ctr[slot] = dir_ctr[slot] - 2'd1;
		end else begin
			victim = -1;
			for (int w = WAYS - 1; w >= 0; w--)
				if (!line_valid[base+w])
					victim = w;
			if (victim < 0) begin
				best = 64;
				for (int w = 0; w < WAYS; w++) begin
					if (line_useful[base+w] < best) begin
						best = int'(line_useful[base+w]);
						victim = w;
					end
				end
			end
			dir_ctr[(base+victim)*CTRS + int'(hist % CTRS)] = {1'b0, actual} + 2'd1;
			line_valid[base+victim] = 1'b1;
			line_tag[base+victim] = tag;
			line_useful[base+victim] = '0;
		end
		return r;
	endfunction

	task automatic send_branch(logic kind, logic [31:0] pc, logic [31:0] hist,
			logic [31:0] extra, logic actual, logic basep, logic tablep);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.branch_pc <= pc;
		req.global_history <= hist;
		req.tag_extra <= extra;
		req.actual_taken <= actual;
		req.base_prediction <= basep;
		req.table_prediction <= tablep;
		do @(posedge clk); while (!req.ready);
		expected_q.push_back(predict_and_update(kind, pc, hist, extra, actual,
			basep, tablep));
	endtask

	task automatic send_random_branch();
		int i;
		logic kind;
		i = $urandom_range(15);
		kind = 1'($urandom_range(1));
		if ($urandom_range(9) < 8)
			send_branch(kind, pool_pc[i], pool_hist[i], pool_extra[i],
				1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		else
			send_branch(kind, $urandom, $urandom, $urandom,
				1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic refresh_pool();
		logic [31:0] shared_set;
		shared_set = $urandom;
		for (int i = 0; i < 16; i++) begin
			// half the pool lands in one set to force evictions
			pool_hist[i] = $urandom;
			pool_pc[i] = (i < 8) ? (shared_set ^ pool_hist[i]) : $urandom;
			pool_pc[i][31:10] = 22'($urandom);
			pool_extra[i] = $urandom_range(3) == 0 ? 32'd0 : $urandom;
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_limit(logic [5:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_q = value;
	endtask

	task automatic run_random(int count);
		refresh_pool();
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				refresh_pool();
			send_random_branch();
		end
	endtask

	task automatic test_directed();
		logic [31:0] h;
		h = 32'h0000_0013;
		send_branch(KIND_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
		send_branch(KIND_FEEDBACK, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b1);
		send_branch(KIND_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
		send_branch(KIND_FEEDBACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b0, 1'b1, 1'b0);
		send_branch(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 1'b1, 1'b1);
		// fill one set past its ways, train the usefulness of one of them
		for (int t = 0; t < 6; t++)
			send_branch(KIND_FEEDBACK, (32'h400 << t) ^ h, h, 32'h0, 1'b1, 1'b0, 1'b1);
		for (int t = 0; t < 6; t++)
			send_branch(KIND_FEEDBACK, (32'h400 << 1) ^ h, h, 32'h0, 1'b1, 1'b0, 1'b1);
		send_branch(KIND_FEEDBACK, (32'h400 << 1) ^ h, h, 32'h0, 1'b0, 1'b0, 1'b0);
		send_branch(KIND_FEEDBACK, (32'h400 << 1) ^ h, h, 32'h0, 1'b0, 1'b0, 1'b0);
		send_branch(KIND_LOOKUP, (32'h400 << 1) ^ h, h, 32'h0, 1'b0, 1'b0, 1'b0);
		send_branch(KIND_FEEDBACK, 32'hDEAD_0000 ^ h, h, 32'h5, 1'b0, 1'b1, 1'b1);
		drain();
	endtask

	task automatic test_limits();
		logic [5:0] limits [5] = '{6'd1, 6'd63, 6'd0, 6'd2, 6'd17};
		foreach (limits[k]) begin
			write_limit(limits[k]);
			run_random(60);
			drain();
		end
		write_limit(LIMIT_RESET);
	endtask

	task automatic test_idle_phases();
		int pats [4][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{6, 6}};
		foreach (pats[k]) begin
			send_idle_pct = pats[k][0];
			recv_stall_pct = pats[k][1];
			run_random(k == 1 || k == 2 ? 150 : 450);
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_off_cycles = 400;
		run_random(20);
		drain();
	endtask

	// result side
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
		if (rsp.valid && rsp.ready) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: hit=%0b", rsp.hit);
				errors++;
			end else begin
				prediction_t e;
				e = expected_q.pop_front();
				if (rsp.hit !== e.hit) begin
					$error("hit: expected %0b, actual %0b", e.hit, rsp.hit);
					errors++;
				end
				if (rsp.predict_taken !== e.predict_taken) begin
					$error("predict_taken: expected %0b, actual %0b",
						e.predict_taken, rsp.predict_taken);
					errors++;
				end
			end
		end
	end

	// watchdog: covers the clearing pass and the long hold-off
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		limit_q = LIMIT_RESET;
		for (int i = 0; i < LINES; i++) begin
			line_valid[i] = 1'b0;
			line_tag[i] = '0;
			line_useful[i] = '0;
		end
		for (int i = 0; i < LINES*CTRS; i++)
			dir_ctr[i] = CTR_INIT;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.kind = KIND_LOOKUP;
		req.branch_pc = '0;
		req.global_history = '0;
		req.tag_extra = '0;
		req.actual_taken = 1'b0;
		req.base_prediction = 1'b0;
		req.table_prediction = 1'b0;
		rsp.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		test_backpressure();
		test_idle_phases();
		drain();
		if (errors == 0 && expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/tbp_pkg.sv
rtl/tbp_if.sv
rtl/tbp_div.sv
rtl/tbp_ctrl.sv
rtl/tbp_datapath.sv
rtl/tagged_branch_overriding_predictor_core.sv
rtl/tbp_checker.sv
test/tagged_branch_overriding_predictor_core_tb.sv
